@@ sv/fpst_pkg.sv @@
// Shared types and constants for the Fenwick prefix-sum table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package fpst_pkg;

    // Field widths of the stream payload and the configuration register
    localparam int unsigned IDX_W  = 11;
    localparam int unsigned DATA_W = 32;
    // Walk position needs one bit more than the index: an add can climb past 2047
    localparam int unsigned POS_W  = IDX_W + 1;

    // Active size after reset
    localparam logic [IDX_W-1:0] ACTIVE_RST = 11'd1024;

    // Request kinds carried in tuser
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;   // write zero at the clear counter and advance it
        logic load;  // take a new request
        logic step;  // read the current node and move to the next one
        logic emit;  // load the prefix sum into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;  // last entry of the clearing pass is being written
        logic more;      // walk has another node to visit
        logic is_query;  // current request is a query
        logic out_free;  // output register can take a new result
    } t_sts;

endpackage

`default_nettype wire

@@ sv/fpst_ctrl.sv @@
// Controller state machine of the Fenwick prefix-sum table.
// Depends on fpst_pkg for the state, command and status types.
`default_nettype none

module fpst_ctrl
    import fpst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                // Advance one node a cycle; the last pending update lands on exit
                if (i_sts.more) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.is_query) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/fpst_dpath.sv @@
// Datapath of the Fenwick prefix-sum table: node store, walk position,
// accumulator, active-size register and output register. Depends on fpst_pkg.
`default_nettype none

module fpst_dpath
    import fpst_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_wdata,
    input  wire logic              i_mode,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic [DATA_W-1:0] i_delta,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output logic [DATA_W-1:0]      o_m_tdata,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts
);

    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW      = (AW > POS_W) ? AW : POS_W;
    localparam int unsigned LIM_CAP = (DEPTH > 2047) ? 2047 : DEPTH;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]  r_active;
    logic [AW-1:0]     r_clr_cnt;
    logic [POS_W-1:0]  r_pos;
    logic              r_mode;
    logic [DATA_W-1:0] r_delta;
    logic [DATA_W-1:0] r_acc;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_data;

    logic [POS_W-1:0]  w_limit;
    logic [POS_W-1:0]  w_low;
    logic [POS_W-1:0]  w_pos_next;
    logic              w_exist;
    logic [XW-1:0]     w_addr_ext;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;

    // Effective climb limit: the smaller of active size and depth
    assign w_limit = (r_active > IDX_W'(LIM_CAP)) ? POS_W'(LIM_CAP) : {1'b0, r_active};

    // Lowest set bit of the position and the next node on either path
    assign w_low      = r_pos & (~r_pos + POS_W'(1));
    assign w_pos_next = (r_mode == MODE_QUERY) ? (r_pos & (r_pos - POS_W'(1)))
                                               : (r_pos + w_low);

    // Nodes above the depth do not exist and count as zero
    assign w_exist    = (32'(r_pos) <= 32'(DEPTH));
    assign w_addr_ext = XW'(r_pos) - XW'(1);
    assign w_raddr    = w_addr_ext[AW-1:0];

    // Status towards the controller
    always_comb begin
        o_sts          = '0;
        o_sts.clr_done = i_cmd.clr && (r_clr_cnt == AW'(DEPTH - 1));
        o_sts.is_query = (r_mode == MODE_QUERY);
        o_sts.more     = (r_pos != '0) && ((r_mode == MODE_QUERY) || (r_pos <= w_limit));
        o_sts.out_free = !r_out_vld || i_m_tready;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // Walk position and request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos   <= {1'b0, i_index};
            r_mode  <= i_mode;
            r_delta <= i_delta;
        end else if (i_cmd.step) begin
            r_pos   <= w_pos_next;
        end
    end

    // Read stage marker: node data arrives in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step && w_exist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_addr <= w_raddr;
        end
    end

    // Node store read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_exist) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    // Write port: zero during the clearing pass, updated node during an add
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_addr;
        w_wdata = r_rd_data + r_delta;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_cnt;
            w_wdata = '0;
        end else if (r_rd_vld && (r_mode == MODE_ADD)) begin
            w_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    // Prefix-sum accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_rd_vld && (r_mode == MODE_QUERY)) begin
            r_acc <= r_acc + r_rd_data;
        end
    end

    // Output register: holds a result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= r_acc;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ sv/fenwick_prefix_sum_table_top.sv @@
// Fenwick prefix-sum table: DEPTH signed 32-bit nodes with add and query requests.
// After reset a clearing pass writes one node a cycle until all DEPTH nodes (1024
// by default) are zero, and no request is taken meanwhile. A request visits n tree
// nodes at one node a cycle through the single read and single write port of the
// node store: an add visits one node per level of its climb, a query one node per
// set bit of its index, so n is at most 11 (the index width; also clog2(DEPTH)+1
// for an add at the default depth). A query waits to emit its result while the
// sink still holds off the previous one. A query result waits in an output
// register, and the next request is taken while it does. Sums wrap modulo 2^32.
// Write active_size only while the block is idle.
// Depends on fpst_pkg, fpst_ctrl and fpst_dpath.
`default_nettype none

module fenwick_prefix_sum_table_top
    import fpst_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration: active_size
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_wdata,
    // Request stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [47:0]       i_s_tdata,   // [10:0] index, [42:11] delta, rest zero
    input  wire logic              i_s_tuser,   // [0] mode: 0 add, 1 query
    // Result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata    // [31:0] prefix_sum
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    fpst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Node store and arithmetic
    fpst_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mode      (i_s_tuser),
        .i_index     (i_s_tdata[IDX_W-1:0]),
        .i_delta     (i_s_tdata[IDX_W+DATA_W-1:IDX_W]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

`ifndef ASSERT_OFF
    // A taken request keeps the block busy for at least the next cycle
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !o_s_tready)
        else $error("request taken while previous one still in progress");

    // A new result never overwrites one the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten before it was taken");

    // The clearing pass and the walk never overlap
    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> (!w_cmd.step && !w_cmd.load && !w_cmd.emit))
        else $error("walk command issued during the clearing pass");
`endif

endmodule

`default_nettype wire

@@ sim/tb_fenwick_prefix_sum_table_top.sv @@
// Self-checking bench for fenwick_prefix_sum_table_top: add and query requests
// against a Fenwick tree predictor held in a small scoreboard class.
// Depends on fpst_pkg and the top level with its submodules.
`default_nettype none

module tb_fenwick_prefix_sum_table_top;
    import fpst_pkg::*;

    localparam int unsigned NODES     = 1024;
    localparam int          STALL_CAP = 4000;  // cycles with no handshake before giving up
    localparam int          SETTLE    = 16;    // longest add plus margin
    localparam int          PER_PHASE = 165;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_wdata = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata   = '0;   // [10:0] index, [42:11] delta, rest zero
    logic              i_s_tuser   = 1'b0; // [0] mode
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;          // [31:0] prefix_sum

    // Predicts prefix sums and checks them in order of issue
    class fenwick_board;
        logic [DATA_W-1:0] nodes [NODES];
        logic [IDX_W-1:0]  active_size;
        logic [DATA_W-1:0] expected_sums [$];
        int                errors;

        function new();
            foreach (nodes[i]) nodes[i] = '0;
            active_size = ACTIVE_RST;
            errors      = 0;
        endfunction

        function void set_active_size(logic [IDX_W-1:0] v);
            active_size = v;
        endfunction

        function int outstanding();
            return expected_sums.size();
        endfunction

        // Add: climb from the index, stopping past the active size or the store depth; query: descend
        function void note_request(logic mode, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] delta);
            logic [IDX_W:0]    pos;
            logic [IDX_W:0]    limit;
            logic [DATA_W-1:0] acc;
            if (mode == MODE_ADD) begin
                limit = (active_size > NODES) ? (IDX_W+1)'(NODES) : {1'b0, active_size};
                pos   = {1'b0, idx};
                while (pos != 0 && pos <= limit) begin
                    nodes[pos - 1] = nodes[pos - 1] + delta;
                    pos = pos + (pos & (~pos + 1'b1));
                end
            end else begin
                // Descend, treating nodes beyond the store as zero
                acc = '0;
                pos = {1'b0, idx};
                while (pos != 0) begin
                    if (pos <= NODES)
                        acc = acc + nodes[pos - 1];
                    pos = pos & (pos - 1'b1);
                end
                expected_sums.insert(expected_sums.size(), acc);
            end
        endfunction

        function void check_sum(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_sums.size() == 0) begin
                $error("prefix_sum: no result expected, got %0d", $signed(got));
                errors++;
            end else begin
                want = expected_sums.pop_front();
                if (got !== want) begin
                    $error("prefix_sum: expected %0d, got %0d", $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    fenwick_board board = new();
    bit           calm  = 1'b0;   // no idling on either side while set
    int           idle_cycles = 0;

    fenwick_prefix_sum_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Watch both handshakes and the stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                board.check_sum(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                board.note_request(i_s_tuser, i_s_tdata[IDX_W-1:0],
                                   i_s_tdata[IDX_W +: DATA_W]);
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random back-pressure, none while calm
    initial begin
        int g;
        forever begin
            g = gap_len();
            if (g == 0) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // Present one request and hold it until taken; call at a rising edge
    task automatic send_request(logic mode, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] delta);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {5'b0, delta, idx};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Hold off requests until every result is back and the last add has finished
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_active_size(logic [IDX_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_active_size(v);
    endtask

    // Index spread: mostly inside the active range, with edges, zero and overflow
    function logic [IDX_W-1:0] pick_index();
        int lim;
        int r;
        lim = (board.active_size == 0) ? NODES :
              (board.active_size > NODES) ? NODES : board.active_size;
        r = $urandom_range(0, 99);
        if (r < 50) return IDX_W'($urandom_range(1, lim));
        if (r < 65) return IDX_W'($urandom_range(1, 16));
        if (r < 75) return '0;
        if (r < 85) return IDX_W'($urandom_range(NODES - 7, NODES));
        if (r < 95) return IDX_W'($urandom_range(NODES + 1, 2047));
        return IDX_W'($urandom());
    endfunction

    function logic [DATA_W-1:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 200) - 100;
        if (r < 85) return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return '0;
        endcase
    endfunction

    initial begin
        logic [IDX_W-1:0] sizes [7];
        sizes[0] = 11'd1;
        sizes[1] = 11'd2047;
        sizes[2] = 11'd0;
        sizes[3] = IDX_W'($urandom_range(2, 1023));
        sizes[4] = 11'd1024;
        sizes[5] = 11'd2;
        sizes[6] = IDX_W'($urandom_range(3, 1023));

        // Reset, then run with the reset active size
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero index, wrap, top node, overflow indexes, bit patterns
        send_request(MODE_QUERY, 11'd0,    32'h1234_5678);
        send_request(MODE_ADD,   11'd0,    32'd5);
        send_request(MODE_ADD,   11'd1,    32'h7FFF_FFFF);
        send_request(MODE_ADD,   11'd1,    32'd1);
        send_request(MODE_QUERY, 11'd1,    '0);
        send_request(MODE_ADD,   11'd1024, 32'h8000_0000);
        send_request(MODE_QUERY, 11'd1024, '0);
        send_request(MODE_ADD,   11'd1023, 32'hFFFF_FFFF);
        send_request(MODE_QUERY, 11'd1023, '0);
        send_request(MODE_QUERY, 11'd2047, 32'hFFFF_FFFF);
        send_request(MODE_ADD,   11'd1025, 32'd77);
        send_request(MODE_ADD,   11'd2047, 32'd99);
        send_request(MODE_ADD,   11'd512,  32'hFFFF_FFFF);
        send_request(MODE_ADD,   11'd3,    32'h5555_5555);
        send_request(MODE_ADD,   11'd6,    32'hAAAA_AAAA);
        send_request(MODE_QUERY, 11'd7,    '0);
        send_request(MODE_QUERY, 11'd1535, '0);
        send_request(MODE_QUERY, 11'd1536, '0);
        send_request(MODE_QUERY, 11'd1024, '0);

        // Random phases, each under a new active size written while idle
        foreach (sizes[p]) begin
            settle();
            write_active_size(sizes[p]);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_request(($urandom_range(0, 99) < 55) ? MODE_ADD : MODE_QUERY,
                             pick_index(), pick_delta());
            end
            calm = 1'b0;
        end

        // Drain and report
        settle();
        if (board.errors == 0 && board.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
